// ===== rtl/gbc_pkg.sv =====
// Shared types, constants and round functions for the GOST block cipher pipeline.
package gbc_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned NumKeys   = 8;
  localparam int unsigned FwdRounds = 24;
  localparam int unsigned RevRounds = 8;
  localparam int unsigned RotAmt    = 11;
  localparam int unsigned HalfW     = 32;
  localparam int unsigned BlockW    = 64;
  localparam int unsigned KeyIdxW   = 3;
  localparam int unsigned CfgIdxW   = 4;

  typedef enum logic {
    FUNC_ENC = 1'b0,
    FUNC_DEC = 1'b1
  } gbc_func_t;

  typedef logic [NumKeys-1:0][HalfW-1:0] gbc_keys_t;

  typedef struct packed {
    logic             valid;
    gbc_func_t        func;
    logic [HalfW-1:0] left;
    logic [HalfW-1:0] right;
  } gbc_stage_t;

  localparam logic [HalfW-1:0] KEY_RESET [NumKeys] = '{
    32'h4FAF51BE, 32'h5C3D20EF, 32'h49BA3FCE, 32'h54C6A33E,
    32'h5B7E3D72, 32'hE95B3FC4, 32'hCE42D79A, 32'hBA591FFE
  };

  localparam logic [3:0] SBOX [8][16] = '{
    '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
      4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
    '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
      4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
    '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
      4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
    '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
      4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
    '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
      4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
    '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
      4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
      4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
    '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
      4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
  };

  // Key word used by a round for the given direction; round is an elaboration constant.
  function automatic logic [KeyIdxW-1:0] key_sel(input int unsigned rnd, input gbc_func_t f);
    logic [KeyIdxW-1:0] ki;
    if (f == FUNC_ENC) begin
      ki = (rnd < FwdRounds) ? KeyIdxW'(rnd) : KeyIdxW'(NumRounds - 1 - rnd);
    end else begin
      ki = (rnd < RevRounds) ? KeyIdxW'(rnd) : KeyIdxW'(NumRounds - 1 - rnd);
    end
    return ki;
  endfunction

  // Substitute all eight nibbles, then rotate left.
  function automatic logic [HalfW-1:0] round_fn(input logic [HalfW-1:0] t);
    logic [HalfW-1:0] u;
    for (int i = 0; i < 8; i++) begin
      u[4*i +: 4] = SBOX[i][t[4*i +: 4]];
    end
    return {u[HalfW-RotAmt-1:0], u[HalfW-1:HalfW-RotAmt]};
  endfunction

endpackage

// ===== rtl/gbc_key_regs.sv =====
// Key word registers written through the configuration channel.
module gbc_key_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  input  logic [gbc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gbc_pkg::HalfW-1:0]   cfg_data,
  output gbc_pkg::gbc_keys_t          keys
);

  gbc_pkg::gbc_keys_t keys_r;
  gbc_pkg::gbc_keys_t keys_nxt;

  always_comb begin
    keys_nxt = keys_r;
    // drop writes beyond the last key word
    if (cfg_valid && (cfg_index < gbc_pkg::CfgIdxW'(gbc_pkg::NumKeys))) begin
      keys_nxt[cfg_index[gbc_pkg::KeyIdxW-1:0]] = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < gbc_pkg::NumKeys; i++) begin
        keys_r[i] <= gbc_pkg::KEY_RESET[i];
      end
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign keys = keys_r;

endmodule

// ===== rtl/gbc_round.sv =====
// One registered Feistel round of the cipher pipeline.
module gbc_round #(
  parameter int unsigned RoundIdx = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gbc_pkg::gbc_stage_t stage_in,
  input  gbc_pkg::gbc_keys_t  keys,
  output gbc_pkg::gbc_stage_t stage_out
);

  localparam logic [gbc_pkg::KeyIdxW-1:0] EncKey =
    gbc_pkg::key_sel(RoundIdx, gbc_pkg::FUNC_ENC);
  localparam logic [gbc_pkg::KeyIdxW-1:0] DecKey =
    gbc_pkg::key_sel(RoundIdx, gbc_pkg::FUNC_DEC);

  logic [gbc_pkg::HalfW-1:0] rkey;
  logic [gbc_pkg::HalfW-1:0] sum;
  gbc_pkg::gbc_stage_t       stage_r;
  gbc_pkg::gbc_stage_t       stage_nxt;

  always_comb begin
    rkey = (stage_in.func == gbc_pkg::FUNC_ENC) ? keys[EncKey] : keys[DecKey];
    sum  = stage_in.right + rkey;
    stage_nxt.valid = stage_in.valid;
    stage_nxt.func  = stage_in.func;
    stage_nxt.left  = stage_in.right;
    stage_nxt.right = gbc_pkg::round_fn(sum) ^ stage_in.left;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else begin
      stage_r.valid <= stage_nxt.valid;
    end
    stage_r.func  <= stage_nxt.func;
    stage_r.left  <= stage_nxt.left;
    stage_r.right <= stage_nxt.right;
  end

  assign stage_out = stage_r;

endmodule

// ===== rtl/gost_block_cipher_ecb.sv =====
// Top level of the pipelined GOST 28147-89 ECB block cipher.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------
//   request  | start / busy           | in_func, in_block_in
//   result   | out_valid (strobe)     | out_block_out
//   config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Each of the 32 rounds owns a register stage, so a request enters every cycle
// while busy is low and its result leaves the last round register; the round
// adder and S-box layer set the stage depth. busy is a registered flag, set while
// reset is applied and cleared once reset is released; it then stays low.
// The result strobe cannot be held off, so the pipeline never stalls.
// Reset clears all stage valid bits and reloads the default key words.
module gost_block_cipher_ecb (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_func,
  input  logic [gbc_pkg::BlockW-1:0]  in_block_in,
  output logic                        out_valid,
  output logic [gbc_pkg::BlockW-1:0]  out_block_out,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gbc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [gbc_pkg::HalfW-1:0]   cfg_data
);

  logic                busy_r;
  logic                accept;
  gbc_pkg::gbc_keys_t  keys;
  gbc_pkg::gbc_stage_t stage_w [gbc_pkg::NumRounds+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy      = busy_r;
  assign accept    = start && !busy_r;
  assign cfg_ready = 1'b1;

  gbc_key_regs u_keys (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  always_comb begin
    stage_w[0].valid = accept;
    stage_w[0].func  = gbc_pkg::gbc_func_t'(in_func);
    stage_w[0].left  = in_block_in[gbc_pkg::BlockW-1:gbc_pkg::HalfW];
    stage_w[0].right = in_block_in[gbc_pkg::HalfW-1:0];
  end

  for (genvar g = 0; g < gbc_pkg::NumRounds; g++) begin : g_round
    gbc_round #(
      .RoundIdx (g)
    ) u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_in  (stage_w[g]),
      .keys      (keys),
      .stage_out (stage_w[g+1])
    );
  end

  // swap halves on the way out
  assign out_valid     = stage_w[gbc_pkg::NumRounds].valid;
  assign out_block_out = {stage_w[gbc_pkg::NumRounds].right,
                          stage_w[gbc_pkg::NumRounds].left};

  a_req_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##32 out_valid)
    else $error("request lost in pipeline");

  a_result_had_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 32))
    else $error("result without a matching request");

  a_not_busy_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule
